/* rtl/look_at_basis_builder_unit_macros.svh */
// Assertion macros shared by the basis builder.
`ifndef LOOK_AT_BASIS_BUILDER_UNIT_MACROS_SVH
`define LOOK_AT_BASIS_BUILDER_UNIT_MACROS_SVH

// Implication in the same cycle, checked on the rising clock edge outside reset.
`define LABB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication against a past value of sig, taken at the delay given by dly.
`define LABB_ASSERT_PAST(lbl, ante, sig, dly, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> $past(sig, dly)) else $error(msg);

`endif

/* rtl/labb_pkg.sv */
// Types and constants of the look-at basis builder.
package labb_pkg;

    localparam int VW = 33;
    localparam int AW = 30;
    localparam int SW = 62;
    localparam int QW = 31;
    localparam int RW = 32;
    localparam int CW = 32;

    localparam logic [15:0] ONE_Q14     = 16'h4000;
    localparam logic [15:0] NEG_ONE_Q14 = 16'hC000;
    localparam logic [16:0] SAT_MAG     = 17'd16384;

    localparam logic [1:0] CFG_UP_X = 2'd0;
    localparam logic [1:0] CFG_UP_Y = 2'd1;
    localparam logic [1:0] CFG_UP_Z = 2'd2;

    localparam int NORM_LAT  = 71;
    localparam int CROSS_LAT = 2;

    typedef logic [2:0][15:0] t_vec;

    typedef struct packed {
        logic look_dn;
        logic look_up;
        logic deg;
        t_vec w;
        t_vec u;
    } t_side;

    typedef struct packed {
        logic             vld;
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][AW-1:0] a;
        t_side            side;
    } t_nctl;

endpackage

/* rtl/labb_cross.sv */
// Two-stage cross product of two Q1.14 vectors.
module labb_cross (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  labb_pkg::t_vec                i_a,
    input  labb_pkg::t_vec                i_b,
    input  labb_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic [2:0][labb_pkg::CW-1:0]  o_c,
    output labb_pkg::t_side               o_side
);

    logic                         r_p_vld;
    logic signed [31:0]           r_p [6];
    labb_pkg::t_side              r_p_side;
    logic                         r_c_vld;
    logic [2:0][labb_pkg::CW-1:0] r_c;
    labb_pkg::t_side              r_c_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_p_vld <= i_vld;
            r_c_vld <= r_p_vld;
        end
        r_p[0] <= $signed(i_a[1]) * $signed(i_b[2]);
        r_p[1] <= $signed(i_a[2]) * $signed(i_b[1]);
        r_p[2] <= $signed(i_a[2]) * $signed(i_b[0]);
        r_p[3] <= $signed(i_a[0]) * $signed(i_b[2]);
        r_p[4] <= $signed(i_a[0]) * $signed(i_b[1]);
        r_p[5] <= $signed(i_a[1]) * $signed(i_b[0]);
        r_p_side <= i_side;
        r_c[0] <= r_p[0] - r_p[1];
        r_c[1] <= r_p[2] - r_p[3];
        r_c[2] <= r_p[4] - r_p[5];
        r_c_side <= r_p_side;
    end

    assign o_vld  = r_c_vld;
    assign o_c    = r_c;
    assign o_side = r_c_side;

endmodule

/* rtl/labb_norm3.sv */
// Pipelined normalisation of a three-component vector to Q1.14.
module labb_norm3 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [2:0][labb_pkg::VW-1:0]  i_v,
    input  labb_pkg::t_side               i_side,
    output logic                          o_vld,
    output logic                          o_zero,
    output labb_pkg::t_vec                o_n,
    output labb_pkg::t_side               o_side
);

    localparam int VW = labb_pkg::VW;
    localparam int AW = labb_pkg::AW;
    localparam int SW = labb_pkg::SW;
    localparam int QW = labb_pkg::QW;
    localparam int RW = labb_pkg::RW;
    localparam logic [5:0] TGT_POS = 6'd29;

    logic                 r1_vld;
    logic [2:0]           r1_neg;
    logic [2:0][VW-1:0]   r1_m;
    logic [VW-1:0]        r1_max;
    logic [VW-1:0]        r1_max_n;
    labb_pkg::t_side      r1_side;

    labb_pkg::t_nctl      n2_ctl;
    labb_pkg::t_nctl      r2_ctl;
    labb_pkg::t_nctl      r3_ctl;
    logic [2*AW-1:0]      r3_sq [3];
    logic [5:0]           n_pos;

    labb_pkg::t_nctl      r_qc    [0:QW];
    logic [QW+1:0]        r_qrem  [0:QW];
    logic [QW-1:0]        r_qroot [0:QW];
    logic [SW-1:0]        r_qs    [0:QW];

    labb_pkg::t_nctl      r_dc    [0:RW];
    logic [QW-1:0]        r_drem  [0:RW];
    logic [RW-1:0]        r_dl    [0:RW];
    logic [RW-1:0]        r_dq    [0:RW];
    logic [QW-1:0]        r_dd    [0:RW];

    labb_pkg::t_nctl      r5_ctl;
    logic [AW+RW-1:0]     r5_p [3];
    logic                 r6_vld;
    logic                 r6_zero;
    labb_pkg::t_vec       r6_n;
    labb_pkg::t_side      r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
        end
        for (int i = 0; i < 3; i++) begin
            r1_neg[i] <= i_v[i][VW-1];
            r1_m[i]   <= i_v[i][VW-1] ? (~i_v[i] + 1'b1) : i_v[i];
        end
        r1_side <= i_side;
    end

    always_comb begin
        logic [VW-1:0] m0;
        logic [VW-1:0] m1;
        m0 = (r1_m[0] > r1_m[1]) ? r1_m[0] : r1_m[1];
        m1 = (m0 > r1_m[2]) ? m0 : r1_m[2];
        r1_max_n = m1;
    end

    always_ff @(posedge i_clk) begin
        r1_max <= r1_max_n;
    end

    logic [2:0][VW-1:0] r1b_m;
    logic [2:0]         r1b_neg;
    labb_pkg::t_side    r1b_side;
    logic               r1b_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1b_vld <= 1'b0;
        end else begin
            r1b_vld <= r1_vld;
        end
        r1b_m    <= r1_m;
        r1b_neg  <= r1_neg;
        r1b_side <= r1_side;
    end

    always_comb begin
        n_pos = '0;
        for (int b = 0; b < VW; b++) begin
            if (r1_max[b]) begin
                n_pos = 6'(b);
            end
        end
        n2_ctl.vld  = r1b_vld;
        n2_ctl.zero = (r1_max == '0);
        n2_ctl.neg  = r1b_neg;
        n2_ctl.side = r1b_side;
        for (int i = 0; i < 3; i++) begin
            if (n_pos < TGT_POS) begin
                n2_ctl.a[i] = AW'(r1b_m[i] << (TGT_POS - n_pos));
            end else begin
                n2_ctl.a[i] = AW'(r1b_m[i] >> (n_pos - TGT_POS));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl.vld <= 1'b0;
            r3_ctl.vld <= 1'b0;
            r_qc[0].vld <= 1'b0;
        end else begin
            r2_ctl <= n2_ctl;
            r3_ctl <= r2_ctl;
            r_qc[0] <= r3_ctl;
        end
        for (int i = 0; i < 3; i++) begin
            r3_sq[i] <= r2_ctl.a[i] * r2_ctl.a[i];
        end
        r_qs[0]    <= SW'(r3_sq[0]) + SW'(r3_sq[1]) + SW'(r3_sq[2]);
        r_qrem[0]  <= '0;
        r_qroot[0] <= '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_sqrt
        logic [QW+3:0] n_sh;
        logic [QW+3:0] n_trial;
        always_comb begin
            n_sh    = {r_qrem[k], r_qs[k][SW-1:SW-2]};
            n_trial = {2'b00, r_qroot[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_qc[k+1].vld <= 1'b0;
            end else begin
                r_qc[k+1] <= r_qc[k];
            end
            r_qs[k+1] <= {r_qs[k][SW-3:0], 2'b00};
            if (n_sh >= n_trial) begin
                r_qrem[k+1]  <= (QW+2)'(n_sh - n_trial);
                r_qroot[k+1] <= {r_qroot[k][QW-2:0], 1'b1};
            end else begin
                r_qrem[k+1]  <= (QW+2)'(n_sh);
                r_qroot[k+1] <= {r_qroot[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc[0].vld <= 1'b0;
        end else begin
            r_dc[0] <= r_qc[QW];
        end
        r_drem[0] <= QW'(1) << (QW - 3);
        r_dl[0]   <= {2'b00, r_qroot[QW][QW-1:1]};
        r_dq[0]   <= '0;
        r_dd[0]   <= r_qroot[QW];
    end

    for (genvar j = 0; j < RW; j++) begin : g_div
        logic [QW:0] n_t;
        always_comb begin
            n_t = {r_drem[j], r_dl[j][RW-1]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dc[j+1].vld <= 1'b0;
            end else begin
                r_dc[j+1] <= r_dc[j];
            end
            r_dl[j+1] <= {r_dl[j][RW-2:0], 1'b0};
            r_dd[j+1] <= r_dd[j];
            if (n_t >= {1'b0, r_dd[j]}) begin
                r_drem[j+1] <= QW'(n_t - {1'b0, r_dd[j]});
                r_dq[j+1]   <= {r_dq[j][RW-2:0], 1'b1};
            end else begin
                r_drem[j+1] <= n_t[QW-1:0];
                r_dq[j+1]   <= {r_dq[j][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl.vld <= 1'b0;
        end else begin
            r5_ctl <= r_dc[RW];
        end
        for (int i = 0; i < 3; i++) begin
            r5_p[i] <= r_dc[RW].a[i] * r_dq[RW];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [AW+RW:0] sum;
        logic [16:0]    m;
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else begin
            r6_vld <= r5_ctl.vld;
        end
        r6_zero <= r5_ctl.zero;
        r6_side <= r5_ctl.side;
        for (int i = 0; i < 3; i++) begin
            sum = {1'b0, r5_p[i]} + ((AW+RW+1)'(1) << 45);
            m   = sum[AW+RW:46];
            if (m > labb_pkg::SAT_MAG) begin
                m = labb_pkg::SAT_MAG;
            end
            r6_n[i] <= r5_ctl.neg[i] ? (16'd0 - m[15:0]) : m[15:0];
        end
    end

    assign o_vld  = r6_vld;
    assign o_zero = r6_zero;
    assign o_n    = r6_n;
    assign o_side = r6_side;

endmodule

/* rtl/look_at_basis_builder_unit.sv */
// Look-at camera basis builder: top level.
// Throughput: one item per cycle; busy is always low, as every stage advances each cycle.
// The depth is set by the two normalisers, each a bit-serial square root and divider pipeline.
// Reset is synchronous and active low; it clears all valid bits and restores the up vector.
`include "look_at_basis_builder_unit_macros.svh"

module look_at_basis_builder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic [31:0] i_eye_x,
    input  logic [31:0] i_eye_y,
    input  logic [31:0] i_eye_z,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    output logic        o_valid,
    output logic [15:0] o_u_x,
    output logic [15:0] o_u_y,
    output logic [15:0] o_u_z,
    output logic [15:0] o_v_x,
    output logic [15:0] o_v_y,
    output logic [15:0] o_v_z,
    output logic [15:0] o_w_x,
    output logic [15:0] o_w_y,
    output logic [15:0] o_w_z,
    output logic        o_degenerate
);

    localparam int VW  = labb_pkg::VW;
    localparam int LAT = 2 * labb_pkg::NORM_LAT + 2 * labb_pkg::CROSS_LAT + 2;

    labb_pkg::t_vec       r_up;
    logic                 r_d_vld;
    logic [2:0][VW-1:0]   r_d;
    labb_pkg::t_side      n_side0;

    logic                 w_vld1;
    logic                 w_zero1;
    labb_pkg::t_vec       w_n1;
    labb_pkg::t_side      w_side1;
    labb_pkg::t_side      n_side1;

    logic                 c_vld1;
    logic [2:0][labb_pkg::CW-1:0] c_c1;
    labb_pkg::t_side      c_side1;
    logic [2:0][VW-1:0]   n_v2;

    logic                 u_vld2;
    logic                 u_zero2;
    labb_pkg::t_vec       u_n2;
    labb_pkg::t_side      u_side2;
    labb_pkg::t_side      n_side2;

    logic                 c_vld2;
    logic [2:0][labb_pkg::CW-1:0] c_c2;
    labb_pkg::t_side      c_side2;

    logic                 r_o_vld;
    labb_pkg::t_vec       r_o_u;
    labb_pkg::t_vec       r_o_v;
    labb_pkg::t_vec       r_o_w;
    logic                 r_o_deg;
    labb_pkg::t_vec       n_u;
    labb_pkg::t_vec       n_v;
    labb_pkg::t_vec       n_w;
    logic                 n_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up[0] <= '0;
            r_up[1] <= labb_pkg::ONE_Q14;
            r_up[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                labb_pkg::CFG_UP_X: r_up[0] <= i_cfg_data;
                labb_pkg::CFG_UP_Y: r_up[1] <= i_cfg_data;
                labb_pkg::CFG_UP_Z: r_up[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= start;
        end
        r_d[0] <= {i_eye_x[31], i_eye_x} - {i_target_x[31], i_target_x};
        r_d[1] <= {i_eye_y[31], i_eye_y} - {i_target_y[31], i_target_y};
        r_d[2] <= {i_eye_z[31], i_eye_z} - {i_target_z[31], i_target_z};
    end

    always_comb begin
        logic vert;
        vert = (r_d[0] == '0) && (r_d[2] == '0);
        n_side0 = '0;
        n_side0.look_dn = vert && !r_d[1][VW-1] && (r_d[1] != '0);
        n_side0.look_up = vert && r_d[1][VW-1];
    end

    labb_norm3 u_norm_w (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_d_vld),
        .i_v    (r_d),
        .i_side (n_side0),
        .o_vld  (w_vld1),
        .o_zero (w_zero1),
        .o_n    (w_n1),
        .o_side (w_side1)
    );

    always_comb begin
        n_side1     = w_side1;
        n_side1.w   = w_n1;
        n_side1.deg = w_zero1;
    end

    labb_cross u_cross_u (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (w_vld1),
        .i_a    (r_up),
        .i_b    (w_n1),
        .i_side (n_side1),
        .o_vld  (c_vld1),
        .o_c    (c_c1),
        .o_side (c_side1)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_v2[i] = {c_c1[i][labb_pkg::CW-1], c_c1[i]};
        end
    end

    labb_norm3 u_norm_u (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (c_vld1),
        .i_v    (n_v2),
        .i_side (c_side1),
        .o_vld  (u_vld2),
        .o_zero (u_zero2),
        .o_n    (u_n2),
        .o_side (u_side2)
    );

    always_comb begin
        n_side2     = u_side2;
        n_side2.u   = u_n2;
        n_side2.deg = u_side2.deg || u_zero2;
    end

    labb_cross u_cross_v (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (u_vld2),
        .i_a    (u_side2.w),
        .i_b    (u_n2),
        .i_side (n_side2),
        .o_vld  (c_vld2),
        .o_c    (c_c2),
        .o_side (c_side2)
    );

    always_comb begin
        logic [labb_pkg::CW-1:0] mg;
        logic [labb_pkg::CW-1:0] rs;
        logic [16:0]             m;
        for (int i = 0; i < 3; i++) begin
            mg = c_c2[i][labb_pkg::CW-1] ? (~c_c2[i] + 1'b1) : c_c2[i];
            rs = (mg + (labb_pkg::CW'(1) << 13)) >> 14;
            m  = rs[16:0];
            if (m > labb_pkg::SAT_MAG) begin
                m = labb_pkg::SAT_MAG;
            end
            n_v[i] = c_c2[i][labb_pkg::CW-1] ? (16'd0 - m[15:0]) : m[15:0];
        end
        n_u   = c_side2.u;
        n_w   = c_side2.w;
        n_deg = 1'b0;
        if (c_side2.look_dn) begin
            n_u = {labb_pkg::ONE_Q14, 16'd0, 16'd0};
            n_v = {16'd0, 16'd0, labb_pkg::ONE_Q14};
            n_w = {16'd0, labb_pkg::ONE_Q14, 16'd0};
        end else if (c_side2.look_up) begin
            n_u = {16'd0, 16'd0, labb_pkg::ONE_Q14};
            n_v = {labb_pkg::ONE_Q14, 16'd0, 16'd0};
            n_w = {16'd0, labb_pkg::NEG_ONE_Q14, 16'd0};
        end else if (c_side2.deg) begin
            n_u   = '0;
            n_v   = '0;
            n_w   = '0;
            n_deg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= c_vld2;
        end
        r_o_u   <= n_u;
        r_o_v   <= n_v;
        r_o_w   <= n_w;
        r_o_deg <= n_deg;
    end

    assign busy         = 1'b0;
    assign o_valid      = r_o_vld;
    assign o_u_x        = r_o_u[0];
    assign o_u_y        = r_o_u[1];
    assign o_u_z        = r_o_u[2];
    assign o_v_x        = r_o_v[0];
    assign o_v_y        = r_o_v[1];
    assign o_v_z        = r_o_v[2];
    assign o_w_x        = r_o_w[0];
    assign o_w_y        = r_o_w[1];
    assign o_w_z        = r_o_w[2];
    assign o_degenerate = r_o_deg;

    `LABB_ASSERT_NOW(a_deg_zero, o_valid && o_degenerate, (r_o_u == '0) && (r_o_v == '0) && (r_o_w == '0), "degenerate item with nonzero basis")
    `LABB_ASSERT_PAST(a_latency, o_valid, start, LAT, "result without an item accepted at the pipeline depth")
    `LABB_ASSERT_NOW(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

/* bench/tb_top.sv */
// Self-checking testbench of the look-at basis builder, with a directed table and random poses.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [15:0] ux, uy, uz, vx, vy, vz, wx, wy, wz;
        logic        deg;
    } t_basis;

    typedef enum int {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [15:0] data;
        logic [31:0] ex, ey, ez, tx, ty, tz;
        bit          typed;
        t_basis      want;
    } t_row;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 160;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk, i_rst_n, start, busy;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic [31:0] i_eye_x, i_eye_y, i_eye_z, i_target_x, i_target_y, i_target_z;
    logic        o_valid, o_degenerate;
    logic [15:0] o_u_x, o_u_y, o_u_z, o_v_x, o_v_y, o_v_z, o_w_x, o_w_y, o_w_z;

    logic        typed_on;
    t_basis      typed_val;

    logic signed [15:0] up_ref [3];
    t_basis pending_bases [$];
    int     mismatches;
    int     idle_cycles;
    bit     gaps_on;
    t_row   rows [$];

    look_at_basis_builder_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned isqrt(input longint unsigned s);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint sat_signed(input bit neg, input longint unsigned m);
        if (m > 16384) m = 16384;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic bit unit_vec(input longint v [3], output longint o [3]);
        longint unsigned a [3];
        longint unsigned mx, s, q, r, m;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (a[i] > mx) mx = a[i];
            o[i] = 0;
        end
        if (mx == 0) return 0;
        while (mx < (64'd1 << 29)) begin
            mx <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
        end
        while (mx >= (64'd1 << 30)) begin
            mx >>= 1;
            for (int i = 0; i < 3; i++) a[i] >>= 1;
        end
        s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        q = isqrt(s);
        r = ((64'd1 << 60) + (q >> 1)) / q;
        for (int i = 0; i < 3; i++) begin
            m = (a[i] * r + (64'd1 << 45)) >> 46;
            o[i] = sat_signed(v[i] < 0, m);
        end
        return 1;
    endfunction

    function automatic void cross_prod(input longint a [3], input longint b [3],
                                       output longint c [3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic t_basis build_basis(input logic [31:0] e [3], input logic [31:0] t [3]);
        longint d [3], w [3], u [3], v [3], c [3], up [3], res [9];
        longint unsigned m;
        t_basis b;
        bit deg;
        deg = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(e[i])) - longint'($signed(t[i]));
            up[i] = longint'(up_ref[i]);
        end
        for (int i = 0; i < 9; i++) res[i] = 0;
        if (d[0] == 0 && d[2] == 0 && d[1] > 0) begin
            res[2] = 16384; res[3] = 16384; res[7] = 16384;
        end else if (d[0] == 0 && d[2] == 0 && d[1] < 0) begin
            res[0] = 16384; res[5] = 16384; res[7] = -16384;
        end else if (!unit_vec(d, w)) begin
            deg = 1;
        end else begin
            cross_prod(up, w, c);
            if (!unit_vec(c, u)) begin
                deg = 1;
            end else begin
                cross_prod(w, u, c);
                for (int i = 0; i < 3; i++) begin
                    m = ((c[i] < 0 ? longint'(-c[i]) : longint'(c[i])) + (64'd1 << 13)) >> 14;
                    v[i] = sat_signed(c[i] < 0, m);
                    res[i] = u[i];
                    res[3 + i] = v[i];
                    res[6 + i] = w[i];
                end
            end
        end
        b.ux = res[0][15:0]; b.uy = res[1][15:0]; b.uz = res[2][15:0];
        b.vx = res[3][15:0]; b.vy = res[4][15:0]; b.vz = res[5][15:0];
        b.wx = res[6][15:0]; b.wy = res[7][15:0]; b.wz = res[8][15:0];
        b.deg = deg;
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    always @(posedge i_clk) begin
        logic [31:0] e [3], t [3];
        t_basis w;
        if (!i_rst_n) begin
            up_ref[0] <= 16'sd0;
            up_ref[1] <= 16'sd16384;
            up_ref[2] <= 16'sd0;
            idle_cycles <= 0;
        end else begin
            if (i_cfg_we && i_cfg_idx != CFG_UNUSED) up_ref[i_cfg_idx] <= i_cfg_data;
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (start && !busy) begin
                e = '{i_eye_x, i_eye_y, i_eye_z};
                t = '{i_target_x, i_target_y, i_target_z};
                pending_bases.push_back(typed_on ? typed_val : build_basis(e, t));
            end
            if (o_valid) begin
                if (pending_bases.size() == 0) begin
                    report_mismatch("unexpected result", 16'(o_valid), 16'd0);
                end else begin
                    w = pending_bases.pop_front();
                    if (o_u_x !== w.ux) report_mismatch("u_x", o_u_x, w.ux);
                    if (o_u_y !== w.uy) report_mismatch("u_y", o_u_y, w.uy);
                    if (o_u_z !== w.uz) report_mismatch("u_z", o_u_z, w.uz);
                    if (o_v_x !== w.vx) report_mismatch("v_x", o_v_x, w.vx);
                    if (o_v_y !== w.vy) report_mismatch("v_y", o_v_y, w.vy);
                    if (o_v_z !== w.vz) report_mismatch("v_z", o_v_z, w.vz);
                    if (o_w_x !== w.wx) report_mismatch("w_x", o_w_x, w.wx);
                    if (o_w_y !== w.wy) report_mismatch("w_y", o_w_y, w.wy);
                    if (o_w_z !== w.wz) report_mismatch("w_z", o_w_z, w.wz);
                    if (o_degenerate !== w.deg)
                        report_mismatch("degenerate", 16'(o_degenerate), 16'(w.deg));
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic add_cfg(input logic [1:0] idx, input logic [15:0] data);
        t_row r;
        r = '{kind: ROW_CFG, default: '0};
        r.idx = idx; r.data = data;
        rows.push_back(r);
    endtask

    task automatic add_item(input logic [31:0] ex, ey, ez, tx, ty, tz,
                            input bit typed, input t_basis want);
        t_row r;
        r = '{kind: ROW_ITEM, default: '0};
        r.ex = ex; r.ey = ey; r.ez = ez; r.tx = tx; r.ty = ty; r.tz = tz;
        r.typed = typed; r.want = want;
        rows.push_back(r);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        start <= 1'b0;
        typed_on <= 1'b0;
        while (pending_bases.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input t_row r);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        start <= 1'b1;
        i_eye_x <= r.ex; i_eye_y <= r.ey; i_eye_z <= r.ez;
        i_target_x <= r.tx; i_target_y <= r.ty; i_target_z <= r.tz;
        typed_on <= r.typed;
        typed_val <= r.want;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        @(negedge i_clk);
    endtask

    task automatic random_pose();
        t_row r;
        int k;
        logic [31:0] base;
        r = '{kind: ROW_ITEM, default: '0};
        r.tx = $urandom; r.ty = $urandom; r.tz = $urandom;
        case ($urandom_range(0, 9)) inside
            [0:3]: begin
                r.ex = $urandom; r.ey = $urandom; r.ez = $urandom;
            end
            [4:5]: begin
                r.ex = r.tx + $signed(32'($urandom_range(0, 2000)) - 1000);
                r.ey = r.ty + $signed(32'($urandom_range(0, 2000)) - 1000);
                r.ez = r.tz + $signed(32'($urandom_range(0, 2000)) - 1000);
            end
            6: begin
                r.ex = r.tx; r.ez = r.tz; r.ey = $urandom;
            end
            7: begin
                r.ex = r.tx; r.ey = r.ty; r.ez = r.tz;
            end
            8: begin
                k = $urandom_range(1, 255) * ($urandom_range(0, 1) ? 1 : -1);
                r.tx = $signed(r.tx) >>> 2; r.ty = $signed(r.ty) >>> 2;
                r.tz = $signed(r.tz) >>> 2;
                r.ex = r.tx + 32'(int'(up_ref[0]) * k);
                r.ey = r.ty + 32'(int'(up_ref[1]) * k);
                r.ez = r.tz + 32'(int'(up_ref[2]) * k);
            end
            default: begin
                base = $urandom;
                r.tx = base; r.ty = base; r.tz = base;
                r.ex = base + $signed(32'($urandom_range(0, 6)) - 3);
                r.ey = base + $signed(32'($urandom_range(0, 6)) - 3);
                r.ez = base + $signed(32'($urandom_range(0, 6)) - 3);
            end
        endcase
        send_item(r);
    endtask

    function automatic logic [15:0] pick_up();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return labb_pkg::ONE_Q14;
            4: return labb_pkg::NEG_ONE_Q14;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_basis dn, upb, zero, deg;
        int phases;
        i_rst_n = 1'b0; start = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_eye_x = '0; i_eye_y = '0; i_eye_z = '0;
        i_target_x = '0; i_target_y = '0; i_target_z = '0;
        typed_on = 1'b0; typed_val = '0;
        mismatches = 0; gaps_on = 1;
        zero = '0;
        dn = '0; dn.uz = labb_pkg::ONE_Q14; dn.vx = labb_pkg::ONE_Q14; dn.wy = labb_pkg::ONE_Q14;
        upb = '0; upb.ux = labb_pkg::ONE_Q14; upb.vz = labb_pkg::ONE_Q14;
        upb.wy = labb_pkg::NEG_ONE_Q14;
        deg = '0; deg.deg = 1'b1;

        add_item(0, 32'h000A0000, 0, 0, 0, 0, 1, dn);
        add_item(0, 32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 1, dn);
        add_item(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, upb);
        add_item(0, 0, 0, 0, 0, 0, 1, deg);
        add_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, deg);
        add_item(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h80000000, 32'h80000000, 32'h80000000, 0, zero);
        add_item(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, zero);
        add_item(1, 0, 0, 0, 0, 0, 0, zero);
        add_item(32'h00030000, 32'h00010000, 32'hFFFE0000, 0, 0, 0, 0, zero);
        add_cfg(labb_pkg::CFG_UP_X, labb_pkg::ONE_Q14);
        add_cfg(labb_pkg::CFG_UP_Y, 16'h0000);
        add_item(32'h00050000, 0, 0, 0, 0, 0, 1, deg);
        add_item(32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0, 0, zero);
        add_cfg(labb_pkg::CFG_UP_X, 16'h0000);
        add_cfg(labb_pkg::CFG_UP_Z, 16'h8000);
        add_item(0, 0, 32'hFFF00000, 0, 0, 0, 1, deg);
        add_cfg(labb_pkg::CFG_UP_Z, 16'h0000);
        add_item(32'h12345678, 32'h0BADF00D, 32'hDEADBEEF, 0, 0, 0, 1, deg);
        add_cfg(CFG_UNUSED, 16'hFFFF);
        add_cfg(labb_pkg::CFG_UP_X, 16'h7FFF);
        add_cfg(labb_pkg::CFG_UP_Y, 16'h8000);
        add_cfg(labb_pkg::CFG_UP_Z, 16'h7FFF);
        add_item(32'h00010000, 0, 0, 0, 0, 0, 0, zero);
        add_item(32'h7FFFFFFF, 32'h00000001, 32'h80000000, 0, 0, 0, 0, zero);
        add_item(32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 0, 0, 0, 0, zero);
        add_cfg(labb_pkg::CFG_UP_X, 16'h0000);
        add_cfg(labb_pkg::CFG_UP_Y, labb_pkg::ONE_Q14);
        add_cfg(labb_pkg::CFG_UP_Z, 16'h0000);

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
            else send_item(rows[i]);
        end

        phases = 6;
        for (int p = 0; p < phases; p++) begin
            if (p > 0) begin
                write_reg(labb_pkg::CFG_UP_X, pick_up());
                write_reg(labb_pkg::CFG_UP_Y, pick_up());
                write_reg(labb_pkg::CFG_UP_Z, pick_up());
                if ($urandom_range(0, 1)) write_reg(CFG_UNUSED, 16'($urandom));
            end
            gaps_on = (p != phases - 1);
            repeat (250) random_pose();
        end
        start <= 1'b0;
        typed_on <= 1'b0;

        while (pending_bases.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending_bases.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
